// ----- hw/rtl/tsoq_pkg.sv -----
package tsoq_pkg;

   // queue geometry
   localparam int QUEUE_DEPTH = 16;
   localparam int SOURCE_BITS = 8;

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   // beat field widths
   localparam int TYPE_W     = 2;
   localparam int STAMP_W    = 32;
   localparam int SOURCE_W   = 8;
   localparam int POSITION_W = 4;
   localparam int COUNT_W    = 5;

   typedef enum logic [TYPE_W-1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_QUERY  = 2'd2
   } tsoq_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT_UP,
      ST_INSERT,
      ST_SHIFT_DOWN,
      ST_FINISH
   } tsoq_state_type;

endpackage

// ----- hw/rtl/tsoq_if.sv -----
interface tsoq_req_if;
   logic                            valid;
   logic                            ready;
   logic [tsoq_pkg::TYPE_W-1:0]     req_type;
   logic [tsoq_pkg::STAMP_W-1:0]    req_stamp;
   logic [tsoq_pkg::SOURCE_W-1:0]   req_source;

   modport source (output valid, output req_type, output req_stamp, output req_source,
                   input ready);
   modport sink   (input valid, input req_type, input req_stamp, input req_source,
                   output ready);
endinterface

interface tsoq_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              found;
   logic [tsoq_pkg::POSITION_W-1:0]   position;
   logic [tsoq_pkg::COUNT_W-1:0]      count;
   logic                              duplicate;
   logic                              overflow;

   modport source (output valid, output found, output position, output count,
                   output duplicate, output overflow, input ready);
   modport sink   (input valid, input found, input position, input count,
                   input duplicate, input overflow, output ready);
endinterface

// ----- hw/rtl/timestamp_ordered_request_queue.sv -----
// operation: the scan reads each queued entry and checks it against the request; an add
//   then moves the entries behind its slot up and writes the new entry, a remove moves
//   the entries behind it down, and the response register is loaded once it is free
// throughput: one item at a time, ready only while idle
// reset: synchronous; clears fill count, sequencer, scan and move flags and response valid, not the entry memory
module timestamp_ordered_request_queue (
   input logic         clock,
   input logic         reset,
   tsoq_req_if.sink    req_chan,
   tsoq_rsp_if.source  rsp_chan
);

   localparam int IDX_W   = tsoq_pkg::IDX_W;
   localparam int CNT_W   = tsoq_pkg::CNT_W;
   localparam int SRC_W   = tsoq_pkg::SOURCE_BITS;
   localparam int STAMP_W = tsoq_pkg::STAMP_W;

   // one queue slot
   typedef struct packed {
      logic [STAMP_W-1:0] stamp;
      logic [SRC_W-1:0]   source;
   } entry_type;

   // strict ordering: older stamp first, lower source breaks ties
   function automatic logic orders_before(input logic [STAMP_W-1:0] sa,
                                          input logic [SRC_W-1:0]   ra,
                                          input logic [STAMP_W-1:0] sb,
                                          input logic [SRC_W-1:0]   rb);
      logic result;
      if (sa != sb) begin
         result = (sa < sb);
      end else begin
         result = (ra < rb);
      end
      return result;
   endfunction

   // sequencer state
   tsoq_pkg::tsoq_state_type state_ff, state_in;

   // number of valid entries
   logic [CNT_W-1:0]   count_ff, count_in;

   // captured request
   logic [tsoq_pkg::TYPE_W-1:0] op_ff, op_in;
   logic [STAMP_W-1:0]          stamp_ff, stamp_in;
   logic [SRC_W-1:0]            src_ff, src_in;

   // scan pipeline: address issued, then data checked in the following cycle
   logic [CNT_W-1:0]   scan_ff, scan_in;
   logic               chk_ff, chk_in;
   logic [IDX_W-1:0]   chk_idx_ff, chk_idx_in;

   // scan results: source match and insertion slot
   logic               hit_ff, hit_in;
   logic [IDX_W-1:0]   hit_pos_ff, hit_pos_in;
   logic [CNT_W-1:0]   at_ff, at_in;

   // entry move: read pointer, moves left, and the write waiting on read data
   logic [IDX_W-1:0]   sh_ff, sh_in;
   logic [CNT_W-1:0]   rem_ff, rem_in;
   logic               wpend_ff, wpend_in;
   logic [IDX_W-1:0]   waddr_ff, waddr_in;

   // result flags held until the response register is free
   logic               res_found_ff, res_found_in;
   logic [IDX_W-1:0]   res_pos_ff, res_pos_in;
   logic               res_dup_ff, res_dup_in;
   logic               res_ovf_ff, res_ovf_in;

   // response register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_found_ff, rsp_found_in;
   logic [tsoq_pkg::POSITION_W-1:0]   rsp_pos_ff, rsp_pos_in;
   logic [tsoq_pkg::COUNT_W-1:0]      rsp_count_ff, rsp_count_in;
   logic                              rsp_dup_ff, rsp_dup_in;
   logic                              rsp_ovf_ff, rsp_ovf_in;

   // entry memory, one write and one registered read per cycle
   entry_type          mem [tsoq_pkg::QUEUE_DEPTH];
   entry_type          rd_data_ff;
   logic [IDX_W-1:0]   rd_addr;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   entry_type          wr_data;

   logic               req_accept;

   assign req_chan.ready = (state_ff == tsoq_pkg::ST_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.found     = rsp_found_ff;
   assign rsp_chan.position  = rsp_pos_ff;
   assign rsp_chan.count     = rsp_count_ff;
   assign rsp_chan.duplicate = rsp_dup_ff;
   assign rsp_chan.overflow  = rsp_ovf_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tsoq_pkg::ST_IDLE;
         count_ff     <= '0;
         chk_ff       <= 1'b0;
         wpend_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         chk_ff       <= chk_in;
         wpend_ff     <= wpend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      stamp_ff     <= stamp_in;
      src_ff       <= src_in;
      scan_ff      <= scan_in;
      chk_idx_ff   <= chk_idx_in;
      hit_ff       <= hit_in;
      hit_pos_ff   <= hit_pos_in;
      at_ff        <= at_in;
      sh_ff        <= sh_in;
      rem_ff       <= rem_in;
      waddr_ff     <= waddr_in;
      res_found_ff <= res_found_in;
      res_pos_ff   <= res_pos_in;
      res_dup_ff   <= res_dup_in;
      res_ovf_ff   <= res_ovf_in;
      rsp_found_ff <= rsp_found_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_count_ff <= rsp_count_in;
      rsp_dup_ff   <= rsp_dup_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      op_in        = op_ff;
      stamp_in     = stamp_ff;
      src_in       = src_ff;
      scan_in      = scan_ff;
      chk_in       = chk_ff;
      chk_idx_in   = chk_idx_ff;
      hit_in       = hit_ff;
      hit_pos_in   = hit_pos_ff;
      at_in        = at_ff;
      sh_in        = sh_ff;
      rem_in       = rem_ff;
      waddr_in     = waddr_ff;
      res_found_in = res_found_ff;
      res_pos_in   = res_pos_ff;
      res_dup_in   = res_dup_ff;
      res_ovf_in   = res_ovf_ff;
      rsp_found_in = rsp_found_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_count_in = rsp_count_ff;
      rsp_dup_in   = rsp_dup_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      // response register drains independently of the sequencer
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      rd_addr = sh_ff;

      // a moved entry is written in the cycle after its read
      wpend_in = 1'b0;
      wr_en    = wpend_ff;
      wr_addr  = waddr_ff;
      wr_data  = rd_data_ff;

      case (state_ff)
         tsoq_pkg::ST_IDLE: begin
            if (req_accept) begin
               op_in      = req_chan.req_type;
               stamp_in   = req_chan.req_stamp;
               src_in     = req_chan.req_source[SRC_W-1:0];
               scan_in    = '0;
               chk_in     = 1'b0;
               hit_in     = 1'b0;
               hit_pos_in = '0;
               at_in      = '0;
               state_in   = tsoq_pkg::ST_SCAN;
            end
         end

         tsoq_pkg::ST_SCAN: begin
            // check the entry read last cycle
            if (chk_ff) begin
               if (rd_data_ff.source == src_ff) begin
                  hit_in     = 1'b1;
                  hit_pos_in = chk_idx_ff;
               end
               // slot lies past every entry that does not order after the new one
               if (!orders_before(stamp_ff, src_ff, rd_data_ff.stamp, rd_data_ff.source)) begin
                  at_in = at_ff + CNT_W'(1);
               end
            end
            if (scan_ff < count_ff) begin
               rd_addr    = scan_ff[IDX_W-1:0];
               chk_in     = 1'b1;
               chk_idx_in = scan_ff[IDX_W-1:0];
               scan_in    = scan_ff + CNT_W'(1);
            end else begin
               chk_in = 1'b0;
               if (!chk_ff) begin
                  // scan drained: decide what to do
                  res_found_in = 1'b0;
                  res_pos_in   = '0;
                  res_dup_in   = 1'b0;
                  res_ovf_in   = 1'b0;
                  state_in     = tsoq_pkg::ST_FINISH;
                  case (op_ff)
                     tsoq_pkg::OP_ADD: begin
                        if (hit_ff) begin
                           res_found_in = 1'b1;
                           res_pos_in   = hit_pos_ff;
                           res_dup_in   = 1'b1;
                        end else if (count_ff == CNT_W'(tsoq_pkg::QUEUE_DEPTH)) begin
                           res_ovf_in = 1'b1;
                        end else begin
                           res_found_in = 1'b1;
                           res_pos_in   = at_ff[IDX_W-1:0];
                           rem_in       = count_ff - at_ff;
                           sh_in        = IDX_W'(count_ff - CNT_W'(1));
                           state_in     = tsoq_pkg::ST_SHIFT_UP;
                        end
                     end
                     tsoq_pkg::OP_REMOVE: begin
                        if (hit_ff) begin
                           rem_in   = count_ff - CNT_W'(1) - CNT_W'(hit_pos_ff);
                           sh_in    = hit_pos_ff + IDX_W'(1);
                           state_in = tsoq_pkg::ST_SHIFT_DOWN;
                        end
                     end
                     tsoq_pkg::OP_QUERY: begin
                        res_found_in = hit_ff;
                        res_pos_in   = hit_ff ? hit_pos_ff : '0;
                     end
                     default: begin
                        // unused code: plain status
                     end
                  endcase
               end
            end
         end

         tsoq_pkg::ST_SHIFT_UP: begin
            // open the slot, moving tail entries up from the back
            if (rem_ff != '0) begin
               rd_addr  = sh_ff;
               wpend_in = 1'b1;
               waddr_in = sh_ff + IDX_W'(1);
               sh_in    = sh_ff - IDX_W'(1);
               rem_in   = rem_ff - CNT_W'(1);
            end else if (!wpend_ff) begin
               state_in = tsoq_pkg::ST_INSERT;
            end
         end

         tsoq_pkg::ST_INSERT: begin
            wr_en          = 1'b1;
            wr_addr        = at_ff[IDX_W-1:0];
            wr_data.stamp  = stamp_ff;
            wr_data.source = src_ff;
            count_in       = count_ff + CNT_W'(1);
            state_in       = tsoq_pkg::ST_FINISH;
         end

         tsoq_pkg::ST_SHIFT_DOWN: begin
            // close the gap, moving tail entries down from the front
            if (rem_ff != '0) begin
               rd_addr  = sh_ff;
               wpend_in = 1'b1;
               waddr_in = sh_ff - IDX_W'(1);
               sh_in    = sh_ff + IDX_W'(1);
               rem_in   = rem_ff - CNT_W'(1);
            end else if (!wpend_ff) begin
               count_in = count_ff - CNT_W'(1);
               state_in = tsoq_pkg::ST_FINISH;
            end
         end

         tsoq_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = res_found_ff;
               rsp_pos_in   = tsoq_pkg::POSITION_W'(res_pos_ff);
               rsp_count_in = tsoq_pkg::COUNT_W'(count_ff);
               rsp_dup_in   = res_dup_ff;
               rsp_ovf_in   = res_ovf_ff;
               state_in     = tsoq_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = tsoq_pkg::ST_IDLE;
         end
      endcase
   end

endmodule
